/* rtl/q4g_pkg.sv */
package q4g_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int QDEPTH_DEF    = 4;

  localparam logic signed [31:0] K_DA   = 32'sd226908346;
  localparam logic signed [31:0] K_DB   = 32'sd846833478;
  localparam logic signed [31:0] K_NEAR = 32'sd667876507;
  localparam logic signed [31:0] K_FAR  = 32'sd47951376;
  localparam logic signed [31:0] K_MID  = 32'sd178956971;
  localparam logic [31:0]        K_TWO_PI_Q28 = 32'd1686629713;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DET = 2'd1;
  localparam logic [1:0] ST_RAD = 2'd2;

  typedef struct packed {
    logic signed [31:0] node0_r;
    logic signed [31:0] node0_z;
    logic signed [31:0] node1_r;
    logic signed [31:0] node1_z;
    logic signed [31:0] node2_r;
    logic signed [31:0] node2_z;
    logic signed [31:0] node3_r;
    logic signed [31:0] node3_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         point_index;
    logic [1:0]         node_index;
    logic signed [31:0] point_radius;
    logic signed [31:0] point_axial;
    logic signed [31:0] measure;
    logic signed [31:0] deriv_r;
    logic signed [31:0] deriv_z;
    logic [1:0]         status;
    logic               last;
  } out_item_t;

  // one Gauss point handed from front to back
  typedef struct packed {
    logic [1:0]         point;
    logic [1:0]         status;
    logic               last;
    logic signed [31:0] rad;
    logic signed [31:0] axl;
    logic signed [32:0] jrx;
    logic signed [32:0] jre;
    logic signed [32:0] jzx;
    logic signed [32:0] jze;
    logic [63:0]        det;
  } pt_entry_t;

  typedef enum logic [1:0] {F_IDLE, F_MAC, F_DET, F_PUSH} front_state_t;
  typedef enum logic [2:0] {B_IDLE, B_MEAS, B_NUM, B_DSET, B_DIV, B_EMIT} back_state_t;

  // Q30 shape value of node n at point q
  function automatic logic signed [31:0] shape_w(input logic [1:0] q, input logic [1:0] n);
    logic [1:0] k;
    k = n - q;
    case (k)
      2'd0:    shape_w = K_NEAR;
      2'd2:    shape_w = K_FAR;
      default: shape_w = K_MID;
    endcase
  endfunction

  // Q31 dN/dxi of node n at point q
  function automatic logic signed [31:0] dxi_c(input logic [1:0] q, input logic [1:0] n);
    logic signed [31:0] m, p;
    m = q[1] ? K_DA : K_DB;
    p = q[1] ? K_DB : K_DA;
    case (n)
      2'd0:    dxi_c = -m;
      2'd1:    dxi_c = m;
      2'd2:    dxi_c = p;
      default: dxi_c = -p;
    endcase
  endfunction

  // Q31 dN/deta of node n at point q
  function automatic logic signed [31:0] deta_c(input logic [1:0] q, input logic [1:0] n);
    logic               sxn;
    logic signed [31:0] m2, p2;
    sxn = (q == 2'd0) || (q == 2'd3);
    m2  = sxn ? K_DB : K_DA;
    p2  = sxn ? K_DA : K_DB;
    case (n)
      2'd0:    deta_c = -m2;
      2'd1:    deta_c = -p2;
      2'd2:    deta_c = p2;
      default: deta_c = m2;
    endcase
  endfunction

endpackage

/* rtl/q4g_queue.sv */
module q4g_queue #(
  parameter int DEPTH = q4g_pkg::QDEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  q4g_pkg::pt_entry_t wdata,
  output logic               full,
  input  logic               pop,
  output q4g_pkg::pt_entry_t rdata,
  output logic               empty
);
  import q4g_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pt_entry_t       mem_r [DEPTH];
  logic [PW-1:0]   wr_r, rd_r;
  logic [CW-1:0]   cnt_r;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("point queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("point queue read while empty");

endmodule

/* rtl/q4g_front.sv */
module q4g_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  q4g_pkg::in_item_t  in_word,
  output logic               q_push,
  output q4g_pkg::pt_entry_t q_data,
  input  logic               q_full
);
  import q4g_pkg::*;

  localparam logic [4:0] MAC_LAST = 5'd16;
  localparam logic [4:0] DET_LAST = 5'd4;

  front_state_t       state_r, state_nxt;
  logic               ib_valid_r;
  in_item_t           ib_r, cw_r;
  logic [4:0]         cnt_r, cnt_nxt;
  logic               start, issue, det_issue, last_push;
  logic [1:0]         iq, inode;
  logic signed [31:0] cr, cz, wv, xv, ev;

  logic               pv_r;
  logic [1:0]         pq_r, pn_r;
  logic signed [63:0] psr_r, psz_r, pa_r, pb_r, pc_r, pd_r;
  logic signed [63:0] asr_r, asz_r, aa_r, ab_r, ac_r, ad_r;
  logic signed [63:0] ssr, ssz, sa, sb, sc, sd;

  logic signed [31:0] rad_r [4];
  logic signed [31:0] axl_r [4];
  logic signed [32:0] jrx_r [4];
  logic signed [32:0] jre_r [4];
  logic signed [32:0] jzx_r [4];
  logic signed [32:0] jze_r [4];
  logic [63:0]        det_r [4];

  logic               dv_r;
  logic [1:0]         dq_r;
  logic signed [63:0] dp1_r, dp2_r;

  logic [1:0]         st [4];
  logic               err_any;
  logic [1:0]         err_q, ep;

  function automatic logic signed [31:0] rnd_q30(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v + 64'sd536870912) >>> 30;
    if (t > 64'sd2147483647) begin
      rnd_q30 = 32'sh7FFFFFFF;
    end else if (t < -64'sd2147483648) begin
      rnd_q30 = 32'sh80000000;
    end else begin
      rnd_q30 = t[31:0];
    end
  endfunction

  function automatic logic signed [32:0] rnd_q31(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v + 64'sd1073741824) >>> 31;
    rnd_q31 = t[32:0];
  endfunction

  assign full = ib_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: if (ib_valid_r) state_nxt = F_MAC;
      F_MAC:  if (cnt_r == MAC_LAST) state_nxt = F_DET;
      F_DET:  if (cnt_r == DET_LAST) state_nxt = F_PUSH;
      F_PUSH: if (q_push && last_push) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    start     = (state_r == F_IDLE) && ib_valid_r;
    issue     = (state_r == F_MAC) && !cnt_r[4];
    det_issue = (state_r == F_DET) && !cnt_r[2];
    q_push    = (state_r == F_PUSH) && !q_full;
    last_push = err_any || (cnt_r[1:0] == 2'd3);
    if (state_nxt != state_r) begin
      cnt_nxt = '0;
    end else if (state_r == F_MAC || state_r == F_DET || q_push) begin
      cnt_nxt = cnt_r + 1'b1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  assign iq    = cnt_r[3:2];
  assign inode = cnt_r[1:0];

  always_comb begin
    case (inode)
      2'd0:    begin cr = cw_r.node0_r; cz = cw_r.node0_z; end
      2'd1:    begin cr = cw_r.node1_r; cz = cw_r.node1_z; end
      2'd2:    begin cr = cw_r.node2_r; cz = cw_r.node2_z; end
      default: begin cr = cw_r.node3_r; cz = cw_r.node3_z; end
    endcase
    wv = shape_w(iq, inode);
    xv = dxi_c(iq, inode);
    ev = deta_c(iq, inode);
  end

  always_comb begin
    ssr = ((pn_r == 2'd0) ? 64'sd0 : asr_r) + psr_r;
    ssz = ((pn_r == 2'd0) ? 64'sd0 : asz_r) + psz_r;
    sa  = ((pn_r == 2'd0) ? 64'sd0 : aa_r) + pa_r;
    sb  = ((pn_r == 2'd0) ? 64'sd0 : ab_r) + pb_r;
    sc  = ((pn_r == 2'd0) ? 64'sd0 : ac_r) + pc_r;
    sd  = ((pn_r == 2'd0) ? 64'sd0 : ad_r) + pd_r;
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (det_r[i] == 64'd0) begin
        st[i] = ST_DET;
      end else if (rad_r[i] <= 32'sd0) begin
        st[i] = ST_RAD;
      end else begin
        st[i] = ST_OK;
      end
    end
    err_any = 1'b0;
    err_q   = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (st[i] != ST_OK) begin
        err_any = 1'b1;
        err_q   = 2'(i);
      end
    end
    ep            = err_any ? err_q : cnt_r[1:0];
    q_data.point  = ep;
    q_data.status = err_any ? st[ep] : ST_OK;
    q_data.last   = err_any || (ep == 2'd3);
    q_data.rad    = rad_r[ep];
    q_data.axl    = axl_r[ep];
    q_data.jrx    = jrx_r[ep];
    q_data.jre    = jre_r[ep];
    q_data.jzx    = jzx_r[ep];
    q_data.jze    = jze_r[ep];
    q_data.det    = det_r[ep];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      ib_valid_r <= 1'b0;
      cnt_r      <= '0;
      pv_r       <= 1'b0;
      dv_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pv_r    <= issue;
      dv_r    <= det_issue;
      if (push && !ib_valid_r) begin
        ib_valid_r <= 1'b1;
      end else if (start) begin
        ib_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !ib_valid_r) begin
      ib_r <= in_word;
    end
    if (start) begin
      cw_r <= ib_r;
    end
    if (issue) begin
      pq_r  <= iq;
      pn_r  <= inode;
      psr_r <= 64'(cr) * 64'(wv);
      psz_r <= 64'(cz) * 64'(wv);
      pa_r  <= 64'(cr) * 64'(xv);
      pb_r  <= 64'(cr) * 64'(ev);
      pc_r  <= 64'(cz) * 64'(xv);
      pd_r  <= 64'(cz) * 64'(ev);
    end
    if (pv_r) begin
      if (pn_r == 2'd3) begin
        rad_r[pq_r] <= rnd_q30(ssr);
        axl_r[pq_r] <= rnd_q30(ssz);
        jrx_r[pq_r] <= rnd_q31(sa);
        jre_r[pq_r] <= rnd_q31(sb);
        jzx_r[pq_r] <= rnd_q31(sc);
        jze_r[pq_r] <= rnd_q31(sd);
      end else begin
        asr_r <= ssr;
        asz_r <= ssz;
        aa_r  <= sa;
        ab_r  <= sb;
        ac_r  <= sc;
        ad_r  <= sd;
      end
    end
    if (det_issue) begin
      dq_r  <= cnt_r[1:0];
      dp1_r <= 64'(jrx_r[cnt_r[1:0]]) * 64'(jze_r[cnt_r[1:0]]);
      dp2_r <= 64'(jre_r[cnt_r[1:0]]) * 64'(jzx_r[cnt_r[1:0]]);
    end
    if (dv_r) begin
      det_r[dq_r] <= (dp1_r > dp2_r) ? ($unsigned(dp1_r) - $unsigned(dp2_r)) : 64'd0;
    end
  end

endmodule

/* rtl/q4g_div.sv */
module q4g_div #(
  parameter int FRAC_BITS = q4g_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [62:0]        num_mag,
  input  logic               neg,
  input  logic [63:0]        den,
  output logic               busy,
  output logic signed [31:0] result
);
  import q4g_pkg::*;

  localparam int LS = 2 * FRAC_BITS;
  localparam int SH = 63 - LS;

  logic        busy_r, ovf_r, neg_r;
  logic [5:0]  cnt_r;
  logic [63:0] rem_r, den_r;
  logic [62:0] lo_r, quo_r, hi;
  logic [64:0] t, diff;
  logic        ge;
  logic [63:0] qsum;
  logic [32:0] mag, nmag;

  assign busy = busy_r;
  assign hi   = num_mag >> SH;
  assign t    = {rem_r, lo_r[62]};
  assign diff = t - {1'b0, den_r};
  assign ge   = (t >= {1'b0, den_r});

  always_comb begin
    qsum = 64'(quo_r) + 64'h4000_0000;
    mag  = qsum[63:31];
    nmag = 33'd0 - mag;
    if (!neg_r) begin
      result = (ovf_r || mag > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : mag[31:0];
    end else begin
      result = (ovf_r || mag > 33'h080000000) ? 32'sh80000000 : nmag[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == 6'd62) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= 64'(hi);
      lo_r  <= num_mag << LS;
      quo_r <= '0;
      ovf_r <= (64'(hi) >= den);
      den_r <= den;
      neg_r <= neg;
    end else if (busy_r) begin
      rem_r <= ge ? diff[63:0] : t[63:0];
      lo_r  <= lo_r << 1;
      quo_r <= {quo_r[61:0], ge};
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("divider restarted while busy");

endmodule

/* rtl/q4g_back.sv */
module q4g_back #(
  parameter int FRAC_BITS = q4g_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  output logic               q_pop,
  input  q4g_pkg::pt_entry_t q_data,
  output logic               empty,
  input  logic               pop,
  output q4g_pkg::out_item_t out_word
);
  import q4g_pkg::*;

  localparam int         MS_SHIFT = 28 + 2 * FRAC_BITS;
  localparam logic [2:0] MS_LAST  = 3'd7;

  back_state_t        state_r, state_nxt;
  pt_entry_t          ent_r;
  logic [1:0]         node_r;
  logic [2:0]         ms_r;
  logic [63:0]        prod_r;
  logic [95:0]        pp_r;
  logic [127:0]       acc_r, acc_rnd, meas_t;
  logic signed [31:0] meas_r, meas_sat;
  logic signed [63:0] m1_r, m2_r, m3_r, m4_r, nr, nz, nr_abs, nz_abs;
  logic               div_start, emit;
  logic               dr_busy, dz_busy;
  logic signed [31:0] dr_res, dz_res;
  out_item_t          out_r;
  logic               out_valid_r;

  assign empty    = !out_valid_r;
  assign out_word = out_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: if (!q_empty) state_nxt = (q_data.status != ST_OK) ? B_EMIT : B_MEAS;
      B_MEAS: if (ms_r == MS_LAST) state_nxt = B_NUM;
      B_NUM:  state_nxt = B_DSET;
      B_DSET: state_nxt = B_DIV;
      B_DIV:  if (!dr_busy && !dz_busy) state_nxt = B_EMIT;
      B_EMIT: begin
        if (emit) begin
          state_nxt = (ent_r.status != ST_OK || node_r == 2'd3) ? B_IDLE : B_NUM;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state_r == B_IDLE) && !q_empty;
    div_start = (state_r == B_DSET);
    emit      = (state_r == B_EMIT) && (!out_valid_r || pop);
  end

  always_comb begin
    acc_rnd  = acc_r + (128'd1 << (MS_SHIFT - 1));
    meas_t   = acc_rnd >> MS_SHIFT;
    meas_sat = (|meas_t[127:31]) ? 32'sh7FFFFFFF : meas_t[31:0];
    nr       = m1_r - m2_r;
    nz       = m3_r - m4_r;
    nr_abs   = nr[63] ? -nr : nr;
    nz_abs   = nz[63] ? -nz : nz;
  end

  q4g_div #(.FRAC_BITS(FRAC_BITS)) u_div_r (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num_mag (nr_abs[62:0]),
    .neg     (nr[63]),
    .den     (ent_r.det),
    .busy    (dr_busy),
    .result  (dr_res)
  );

  q4g_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num_mag (nz_abs[62:0]),
    .neg     (nz[63]),
    .den     (ent_r.det),
    .busy    (dz_busy),
    .result  (dz_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      node_r      <= '0;
      ms_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        node_r <= '0;
        ms_r   <= '0;
      end else begin
        if (state_r == B_MEAS) begin
          ms_r <= ms_r + 1'b1;
        end
        if (emit) begin
          node_r <= node_r + 1'b1;
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r <= q_data;
    end
    if (state_r == B_MEAS) begin
      case (ms_r)
        3'd0: prod_r <= 64'(ent_r.rad[31:0]) * 64'(ent_r.det[31:0]);
        3'd1: begin
          pp_r   <= 96'(prod_r);
          prod_r <= 64'(ent_r.rad[31:0]) * 64'(ent_r.det[63:32]);
        end
        3'd2: pp_r <= pp_r + (96'(prod_r) << 32);
        3'd3: prod_r <= 64'(pp_r[31:0]) * 64'(K_TWO_PI_Q28);
        3'd4: begin
          acc_r  <= 128'(prod_r);
          prod_r <= 64'(pp_r[63:32]) * 64'(K_TWO_PI_Q28);
        end
        3'd5: begin
          acc_r  <= acc_r + (128'(prod_r) << 32);
          prod_r <= 64'(pp_r[95:64]) * 64'(K_TWO_PI_Q28);
        end
        3'd6: acc_r <= acc_r + (128'(prod_r) << 64);
        default: meas_r <= meas_sat;
      endcase
    end
    if (state_r == B_NUM) begin
      m1_r <= 64'(ent_r.jze) * 64'(dxi_c(ent_r.point, node_r));
      m2_r <= 64'(ent_r.jzx) * 64'(deta_c(ent_r.point, node_r));
      m3_r <= 64'(ent_r.jrx) * 64'(deta_c(ent_r.point, node_r));
      m4_r <= 64'(ent_r.jre) * 64'(dxi_c(ent_r.point, node_r));
    end
    if (emit) begin
      out_r.point_index  <= ent_r.point;
      out_r.point_radius <= ent_r.rad;
      out_r.point_axial  <= ent_r.axl;
      out_r.status       <= ent_r.status;
      if (ent_r.status != ST_OK) begin
        out_r.node_index <= 2'd0;
        out_r.measure    <= 32'sd0;
        out_r.deriv_r    <= 32'sd0;
        out_r.deriv_z    <= 32'sd0;
        out_r.last       <= 1'b1;
      end else begin
        out_r.node_index <= node_r;
        out_r.measure    <= meas_r;
        out_r.deriv_r    <= dr_res;
        out_r.deriv_z    <= dz_res;
        out_r.last       <= ent_r.last && (node_r == 2'd3);
      end
    end
  end

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != ST_OK |-> out_r.last)
    else $error("error word without last");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != ST_OK |->
      out_r.measure == 32'sd0 && out_r.deriv_r == 32'sd0 && out_r.deriv_z == 32'sd0)
    else $error("error word carries nonzero data");

endmodule

/* rtl/quad4_axisymmetric_geometry.sv */
// Axisymmetric Quad4 geometry unit. An input word carries the four (r,z) corners of an element
// in signed Q16.16; the block returns, point by point and node by node, the radius, axial
// coordinate, 2*pi*r*det measure and the physical shape derivatives at the 2x2 Gauss points,
// 16 words per valid element. An element whose determinant or radius is not positive at some
// point gives a single word with the error status and last set. The front end works an element
// in steps: six parallel multiply-accumulates, then the determinants, then the queue writes.
// The back end sets the throughput: it forms the measure once per point, and for each word two
// bit-serial dividers produce one quotient bit per cycle; an error element skips the dividers.
// A queue of QUEUE_DEPTH points and a one-word output register decouple the stages, and the
// input register takes the next element while the current one is processed.
module quad4_axisymmetric_geometry #(
  parameter int FRAC_BITS   = q4g_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = q4g_pkg::QDEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  q4g_pkg::in_item_t  in_word,
  output logic               empty,
  input  logic               pop,
  output q4g_pkg::out_item_t out_word
);
  import q4g_pkg::*;

  logic      qw_push, qw_full, qr_pop, qr_empty;
  pt_entry_t qw_data, qr_data;

  q4g_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_word (in_word),
    .q_push  (qw_push),
    .q_data  (qw_data),
    .q_full  (qw_full)
  );

  q4g_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (qw_push),
    .wdata (qw_data),
    .full  (qw_full),
    .pop   (qr_pop),
    .rdata (qr_data),
    .empty (qr_empty)
  );

  q4g_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (qr_empty),
    .q_pop    (qr_pop),
    .q_data   (qr_data),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
  );

endmodule
